/* hdl/assert_macros.svh */
// Assertion macros shared by the edge map pruning filter RTL.
// Self-contained; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define EMPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edge map filter check failed");

// next-cycle implication, disabled in reset
`define EMPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edge map filter check failed");

`endif

/* hdl/empf_pkg.sv */
// Types and fixed constants of the edge map pruning filter.
// No dependencies; imported by edge_map_pruning_filter_core.
package empf_pkg;

   // one input transaction
   typedef struct packed {
      logic       action;
      logic [7:0] gray;
      logic [7:0] edge_in;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] edge_out;
      logic [9:0] out_row;
      logic [9:0] out_col;
      logic       last;
   } rsp_type;

   // action codes
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // register indexes
   localparam logic [1:0] REG_FRAME_WIDTH    = 2'd0;
   localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_CONTRAST_THR   = 2'd2;
   localparam logic [1:0] REG_MIN_DIRECTIONS = 2'd3;

   // register reset values
   localparam logic [10:0] RST_FRAME_WIDTH    = 11'd640;
   localparam logic [10:0] RST_FRAME_HEIGHT   = 11'd480;
   localparam logic [7:0]  RST_CONTRAST_THR   = 8'd10;
   localparam logic [3:0]  RST_MIN_DIRECTIONS = 4'd4;

   localparam logic [7:0]  EDGE_MARK  = 8'd255;
   localparam logic [10:0] MAX_HEIGHT = 11'd1024;
   localparam int          ROW_W      = 11;

   // eight search directions of the second pass
   localparam int DIR_DR [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
   localparam int DIR_DC [8] = '{1, 1, 0, -1, -1, -1, 0, 1};

endpackage

/* hdl/edge_map_pruning_filter_core.sv */
// The transaction of the pixel that completes a window (LAG rows and LAG columns past the
// result pixel, LAG = RING_RADIUS + REACH) passes stages 0, 1 and 2 into the result register.
// Throughput: one transaction per cycle unless the output stalls, one read and one write of
// each column-addressed line memory per transaction. Reset is synchronous: counters, valids and
// registers take their defaults; line memories are not cleared, stale rows are masked by frame
// bounds. Depends on empf_pkg and assert_macros.svh; frame width is expected to exceed LAG.
`include "assert_macros.svh"

module edge_map_pruning_filter_core
   import empf_pkg::*;
#(
   parameter int MAX_WIDTH   = 1024,
   parameter int REACH       = 7,
   parameter int RING_RADIUS = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int W_BITS = $clog2(MAX_WIDTH);
   localparam int CRD_W  = (W_BITS > 10 ? W_BITS : 10) + 3;
   localparam int RR     = RING_RADIUS;
   localparam int RH     = RING_RADIUS / 2;
   localparam int GW     = 2 * RR + 1;
   localparam int KW     = 2 * REACH + 1;
   localparam int LAG    = RR + REACH;
   localparam int MA_W   = 2 * RR * 16;
   localparam int MB_KW  = 2 * REACH;
   localparam int MB_W   = MB_KW + 9 * REACH;

   localparam int RING_DR [8] = '{0, RH, RR, RR, RR, RR, RR, RH};
   localparam int RING_DC [8] = '{RR, RR, RR, RH, 0, -RH, -RR, -RR};

   // configuration registers
   logic [10:0] frame_width_ff, frame_height_ff;
   logic [7:0]  contrast_thr_ff;
   logic [3:0]  min_dir_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];

   // write a register on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         contrast_thr_ff <= RST_CONTRAST_THR;
         min_dir_ff      <= RST_MIN_DIRECTIONS;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_FRAME_WIDTH:    frame_width_ff  <= pwdata[10:0];
            REG_FRAME_HEIGHT:   frame_height_ff <= pwdata[10:0];
            REG_CONTRAST_THR:   contrast_thr_ff <= pwdata[7:0];
            REG_MIN_DIRECTIONS: min_dir_ff      <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      case (csr_idx)
         REG_FRAME_WIDTH:    prdata = {21'd0, frame_width_ff};
         REG_FRAME_HEIGHT:   prdata = {21'd0, frame_height_ff};
         REG_CONTRAST_THR:   prdata = {24'd0, contrast_thr_ff};
         REG_MIN_DIRECTIONS: prdata = {28'd0, min_dir_ff};
         default:            prdata = '0;
      endcase
   end

   // clamp frame size
   logic [W_BITS:0]          w_eff;
   logic [10:0]              h_eff;
   logic signed [CRD_W-1:0]  w_s, h_s;

   always_comb begin
      if (frame_width_ff == 11'd0)
         w_eff = (W_BITS+1)'(1);
      else if (int'(frame_width_ff) > MAX_WIDTH)
         w_eff = (W_BITS+1)'(MAX_WIDTH);
      else
         w_eff = (W_BITS+1)'(frame_width_ff);
      if (frame_height_ff == 11'd0)
         h_eff = 11'd1;
      else if (frame_height_ff > MAX_HEIGHT)
         h_eff = MAX_HEIGHT;
      else
         h_eff = frame_height_ff;
   end

   assign w_s = signed'(CRD_W'(w_eff));
   assign h_s = signed'(CRD_W'(h_eff));

   // handshake
   logic enable, accept, complete, enter, wrap_pt;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;
   assign accept    = req_valid && enable;

   // input position counter, runs on past the frame while flushing
   logic [ROW_W-1:0]  in_row_ff, in_row_in;
   logic [W_BITS-1:0] in_col_ff, in_col_in;
   logic [W_BITS:0]   col_inc;

   assign complete = in_row_ff >= h_eff;
   assign enter    = accept && (req_data.action == ACTION_PIXEL || complete);
   assign wrap_pt  = (in_row_ff == h_eff + ROW_W'(LAG)) && (in_col_ff == W_BITS'(LAG - 1));
   assign col_inc  = {1'b0, in_col_ff} + (W_BITS+1)'(1);

   always_comb begin
      in_row_in = in_row_ff;
      in_col_in = in_col_ff;
      if (wrap_pt) begin
         in_row_in = '0;
         in_col_in = '0;
      end else if (col_inc >= w_eff) begin
         in_row_in = in_row_ff + ROW_W'(1);
         in_col_in = '0;
      end else begin
         in_col_in = col_inc[W_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff <= '0;
         in_col_ff <= '0;
      end else if (enter) begin
         in_row_ff <= in_row_in;
         in_col_ff <= in_col_in;
      end
   end

   // ---------------- stage 0: input register and gray/edge line memory
   logic              s0_valid_ff;
   logic [7:0]        s0_gray_ff, s0_edge_ff;
   logic [ROW_W-1:0]  s0_row_ff;
   logic [W_BITS-1:0] s0_col_ff;
   logic [MA_W-1:0]   mem_a [MAX_WIDTH];
   logic [MA_W-1:0]   rda_ff, mem_a_in;
   logic [15:0]       col_a [GW];

   always_ff @(posedge clock) begin
      if (reset)
         s0_valid_ff <= 1'b0;
      else if (enable)
         s0_valid_ff <= enter;
   end

   always_ff @(posedge clock) begin
      if (enter) begin
         s0_gray_ff <= req_data.gray;
         s0_edge_ff <= req_data.edge_in;
         s0_row_ff  <= in_row_ff;
         s0_col_ff  <= in_col_ff;
         rda_ff     <= mem_a[in_col_ff];
      end
      if (enable && s0_valid_ff)
         mem_a[s0_col_ff] <= mem_a_in;
   end

   // newest column of the gray window, and the shifted memory word
   always_comb begin
      col_a[0] = {s0_gray_ff, s0_edge_ff};
      for (int k = 1; k < GW; k++)
         col_a[k] = rda_ff[(k-1)*16 +: 16];
      for (int k = 0; k < 2 * RR; k++)
         mem_a_in[k*16 +: 16] = col_a[k];
   end

   // centre of the first-pass window
   logic                     c1_wrap;
   logic signed [CRD_W-1:0]  c1_row;
   logic [W_BITS:0]          c1_col_full;
   logic [W_BITS-1:0]        c1_col;

   assign c1_wrap     = int'(s0_col_ff) < RR;
   assign c1_row      = signed'(CRD_W'(s0_row_ff)) - signed'(CRD_W'(RR))
                        - signed'(CRD_W'(c1_wrap));
   assign c1_col_full = {1'b0, s0_col_ff} + (c1_wrap ? w_eff : '0) - (W_BITS+1)'(RR);
   assign c1_col      = c1_col_full[W_BITS-1:0];

   // ---------------- stage 1: gray window, contrast test, kept-bit memory
   logic                     s1_valid_ff;
   logic signed [CRD_W-1:0]  s1_row_ff;
   logic [W_BITS-1:0]        s1_col_ff;
   logic [15:0]              gwin_ff [GW][GW];
   logic [MB_W-1:0]          mem_b [MAX_WIDTH];
   logic [MB_W-1:0]          rdb_ff, mem_b_in;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (enable)
         s1_valid_ff <= s0_valid_ff;
   end

   // shift the gray window and fetch the kept-bit column
   always_ff @(posedge clock) begin
      if (enable && s0_valid_ff) begin
         for (int k = 0; k < GW; k++) begin
            gwin_ff[k][0] <= col_a[k];
            for (int m = 1; m < GW; m++)
               gwin_ff[k][m] <= gwin_ff[k][m-1];
         end
         s1_row_ff <= c1_row;
         s1_col_ff <= c1_col;
         rdb_ff    <= mem_b[c1_col];
      end
      if (enable && s1_valid_ff)
         mem_b[s1_col_ff] <= mem_b_in;
   end

   logic [GW-1:0]            rowok1, colok1;
   logic                     cok1, kept1;
   logic [7:0]               edge1;

   // frame bounds around the first-pass centre
   always_comb begin
      logic signed [CRD_W-1:0] rr, cc;
      for (int i = 0; i < GW; i++) begin
         rr = s1_row_ff + signed'(CRD_W'(i - RR));
         cc = signed'(CRD_W'(s1_col_ff)) + signed'(CRD_W'(i - RR));
         rowok1[i] = (rr >= 0) && (rr < h_s);
         colok1[i] = (cc >= 0) && (cc < w_s);
      end
   end

   // opposite ring pairs: keep when any pair differs by more than the threshold
   always_comb begin
      logic [7:0] ga, gb, gd;
      cok1 = 1'b0;
      for (int k = 0; k < 8; k++) begin
         ga = (rowok1[RR + RING_DR[k]] && colok1[RR + RING_DC[k]]) ?
              gwin_ff[RR - RING_DR[k]][RR - RING_DC[k]][15:8] : 8'd0;
         gb = (rowok1[RR - RING_DR[k]] && colok1[RR - RING_DC[k]]) ?
              gwin_ff[RR + RING_DR[k]][RR + RING_DC[k]][15:8] : 8'd0;
         gd = (ga > gb) ? ga - gb : gb - ga;
         if (gd > contrast_thr_ff)
            cok1 = 1'b1;
      end
   end

   assign edge1 = gwin_ff[RR][RR][7:0];
   assign kept1 = rowok1[RR] && colok1[RR] && (edge1 == EDGE_MARK) && cok1;

   // newest kept column and the delayed centre data
   logic [KW-1:0] col_k;
   logic [8:0]    dnew;

   always_comb begin
      col_k[0] = kept1;
      for (int k = 1; k < KW; k++)
         col_k[k] = rdb_ff[k-1];
      for (int k = 0; k < MB_KW; k++)
         mem_b_in[k] = col_k[k];
      mem_b_in[MB_KW +: 9] = {cok1, edge1};
      for (int d = 1; d < REACH; d++)
         mem_b_in[MB_KW + d*9 +: 9] = rdb_ff[MB_KW + (d-1)*9 +: 9];
      dnew = rdb_ff[MB_KW + (REACH-1)*9 +: 9];
   end

   // centre of the second-pass window
   logic                     c2_wrap;
   logic signed [CRD_W-1:0]  c2_row;
   logic [W_BITS:0]          c2_col_full;

   assign c2_wrap     = int'(s1_col_ff) < REACH;
   assign c2_row      = s1_row_ff - signed'(CRD_W'(REACH)) - signed'(CRD_W'(c2_wrap));
   assign c2_col_full = {1'b0, s1_col_ff} + (c2_wrap ? w_eff : '0) - (W_BITS+1)'(REACH);

   // ---------------- stage 2: kept window and direction count
   logic                     s2_valid_ff;
   logic signed [CRD_W-1:0]  s2_row_ff;
   logic [W_BITS-1:0]        s2_col_ff;
   logic                     kwin_ff [KW][KW];
   logic [8:0]               dwin_ff [REACH+1];

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else if (enable)
         s2_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (enable && s1_valid_ff) begin
         for (int k = 0; k < KW; k++) begin
            kwin_ff[k][0] <= col_k[k];
            for (int m = 1; m < KW; m++)
               kwin_ff[k][m] <= kwin_ff[k][m-1];
         end
         dwin_ff[0] <= dnew;
         for (int m = 1; m <= REACH; m++)
            dwin_ff[m] <= dwin_ff[m-1];
         s2_row_ff <= c2_row;
         s2_col_ff <= c2_col_full[W_BITS-1:0];
      end
   end

   logic [KW-1:0] rowok2, colok2;
   logic [7:0]    hit;
   logic [3:0]    dir_count;
   logic          cok2, emit, last2;
   logic [7:0]    edge2, val2;

   always_comb begin
      logic signed [CRD_W-1:0] rr, cc;
      for (int i = 0; i < KW; i++) begin
         rr = s2_row_ff + signed'(CRD_W'(i - REACH));
         cc = signed'(CRD_W'(s2_col_ff)) + signed'(CRD_W'(i - REACH));
         rowok2[i] = (rr >= 0) && (rr < h_s);
         colok2[i] = (cc >= 0) && (cc < w_s);
      end
   end

   // mark each direction that holds a kept edge within reach
   always_comb begin
      int dr, dc;
      hit = '0;
      for (int k = 0; k < 8; k++) begin
         for (int s = 1; s <= REACH; s++) begin
            dr = DIR_DR[k] * s;
            dc = DIR_DC[k] * s;
            if (kwin_ff[REACH - dr][REACH - dc] && rowok2[REACH + dr] && colok2[REACH + dc])
               hit[k] = 1'b1;
         end
      end
   end

   assign dir_count = 4'($countones(hit));
   assign cok2      = dwin_ff[REACH][8];
   assign edge2     = dwin_ff[REACH][7:0];

   // drop low-contrast pixels, then isolated edges
   always_comb begin
      if (!cok2)
         val2 = 8'd0;
      else if (edge2 != EDGE_MARK)
         val2 = edge2;
      else if (dir_count < min_dir_ff)
         val2 = 8'd0;
      else
         val2 = edge2;
   end

   assign emit  = s2_valid_ff && !s2_row_ff[CRD_W-1];
   assign last2 = (s2_row_ff == h_s - signed'(CRD_W'(1)))
                  && ({1'b0, s2_col_ff} == w_eff - (W_BITS+1)'(1));

   // ---------------- result register
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (enable)
         rsp_valid_ff <= emit;
   end

   always_ff @(posedge clock) begin
      if (enable && emit) begin
         rsp_data_ff.edge_out <= val2;
         rsp_data_ff.out_row  <= s2_row_ff[9:0];
         rsp_data_ff.out_col  <= 10'(s2_col_ff);
         rsp_data_ff.last     <= last2;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks
   `EMPF_ASSERT_NEXT(a_early_flush_dropped, clock, reset,
      accept && req_data.action == ACTION_FLUSH && !complete, !s0_valid_ff)
   `EMPF_ASSERT_NEXT(a_counter_restart, clock, reset,
      enter && wrap_pt, in_row_ff == '0 && in_col_ff == '0)
   `EMPF_ASSERT_NOW(a_no_kept_outside, clock, reset,
      s1_valid_ff && !rowok1[RR], !kept1)
   `EMPF_ASSERT_NEXT(a_stall_holds_pipe, clock, reset,
      req_stall, $stable(s0_valid_ff) && $stable(rsp_valid_ff))

endmodule

/* tb/sv/tb_edge_map_pruning_filter_core.sv */
// Self-checking testbench of edge_map_pruning_filter_core: frames of gray/edge pixels
// under several register settings and handshake pressures, checked by a pruning predictor.
// Depends on empf_pkg and the core RTL.
module tb_edge_map_pruning_filter_core;
   import empf_pkg::*;

   localparam int LAG       = 9;
   localparam int REACH_N   = 7;
   localparam int RING_ROWS = 64;
   localparam int WIDTH_MAX = 1024;
   localparam int WATCHDOG  = 4000;
   localparam int SETTLE    = 12;
   localparam int PHASE_LEN = 340;

   // pruning predictor and store of expected pruned pixels
   class prune_scoreboard;
      int unsigned width_reg, height_reg, thr_reg, min_dir_reg;
      logic [7:0] gray_mem [RING_ROWS][WIDTH_MAX];
      logic [7:0] edge_mem [RING_ROWS][WIDTH_MAX];
      int in_row, in_col, res_row, res_col;
      rsp_type pending_px [$];
      int mismatches;

      function new();
         width_reg = 32'(RST_FRAME_WIDTH);
         height_reg = 32'(RST_FRAME_HEIGHT);
         thr_reg = 32'(RST_CONTRAST_THR);
         min_dir_reg = 32'(RST_MIN_DIRECTIONS);
         in_row = 0; in_col = 0; res_row = 0; res_col = 0;
         mismatches = 0;
      endfunction

      function int eff_w();
         return (width_reg < 1) ? 1 : (width_reg > WIDTH_MAX) ? WIDTH_MAX : width_reg;
      endfunction

      function int eff_h();
         return (height_reg < 1) ? 1 : (height_reg > 1024) ? 1024 : height_reg;
      endfunction

      function bit in_frame(int r, int c);
         return r >= 0 && c >= 0 && r < eff_h() && c < eff_w();
      endfunction

      function int gray_px(int r, int c);
         if (!in_frame(r, c)) return 0;
         return gray_mem[r % RING_ROWS][c];
      endfunction

      function int edge_px(int r, int c);
         if (!in_frame(r, c)) return 0;
         return edge_mem[r % RING_ROWS][c];
      endfunction

      // first pass: some opposite pair on the radius-2 ring differs enough
      function bit has_contrast(int r, int c);
         int rdr [8] = '{0, 1, 2, 2, 2, 2, 2, 1};
         int rdc [8] = '{2, 2, 2, 1, 0, -1, -2, -2};
         int a, b, d;
         for (int k = 0; k < 8; k++) begin
            a = gray_px(r + rdr[k], c + rdc[k]);
            b = gray_px(r - rdr[k], c - rdc[k]);
            d = (a > b) ? a - b : b - a;
            if (d > thr_reg) return 1;
         end
         return 0;
      endfunction

      function bit survives_first(int r, int c);
         if (!in_frame(r, c)) return 0;
         return edge_px(r, c) == EDGE_MARK && has_contrast(r, c);
      endfunction

      // second pass: count directions holding a kept edge within reach
      function logic [7:0] pruned_value(int r, int c);
         int e, hits;
         e = edge_px(r, c);
         hits = 0;
         if (!has_contrast(r, c)) return 8'd0;
         if (e != EDGE_MARK) return e[7:0];
         for (int k = 0; k < 8; k++)
            for (int s = 1; s <= REACH_N; s++)
               if (survives_first(r + DIR_DR[k] * s, c + DIR_DC[k] * s)) begin
                  hits++;
                  break;
               end
         return (hits < min_dir_reg) ? 8'd0 : e[7:0];
      endfunction

      // note an accepted input transaction and queue the result it causes
      function void note_input(req_type t);
         int w, h;
         longint have, need;
         bit done, fin;
         rsp_type r;
         w = eff_w();
         h = eff_h();
         done = in_row >= h;
         if (!done) begin
            if (t.action == ACTION_FLUSH) return;
            gray_mem[in_row % RING_ROWS][in_col] = t.gray;
            edge_mem[in_row % RING_ROWS][in_col] = t.edge_in;
            in_col++;
            if (in_col >= w) begin
               in_col = 0;
               in_row++;
            end
            done = in_row >= h;
         end
         if (!done) begin
            have = longint'(in_row) * w + in_col;
            need = longint'(res_row) * w + res_col + longint'(LAG) * w + LAG + 1;
            if (have < need) return;
         end
         fin = (res_row + 1 >= h) && (res_col + 1 >= w);
         r.edge_out = pruned_value(res_row, res_col);
         r.out_row = res_row[9:0];
         r.out_col = res_col[9:0];
         r.last = fin;
         pending_px = {pending_px, r};
         if (fin) begin
            in_row = 0; in_col = 0; res_row = 0; res_col = 0;
         end else begin
            res_col++;
            if (res_col >= w) begin
               res_col = 0;
               res_row++;
            end
         end
      endfunction

      // compare a result transaction with the oldest expectation
      function void check_result(rsp_type got);
         rsp_type want;
         if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: edge %0d row %0d col %0d last %0d",
                        got.edge_out, got.out_row, got.out_col, got.last);
            return;
         end
         want = pending_px.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected edge %0d row %0d col %0d last %0d, got %0d %0d %0d %0d",
                        want.edge_out, want.out_row, want.out_col, want.last,
                        got.edge_out, got.out_row, got.out_col, got.last);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   prune_scoreboard sb = new();
   req_type pixel_q [$];
   int  idle_pct = 0;
   int  stall_pct = 0;
   int  sent = 0;
   bit  req_taken = 1'b0;
   int  quiet_cycles = 0;

   edge_map_pruning_filter_core dut (
      .clock, .reset, .req_valid, .req_stall, .req_data, .rsp_valid, .rsp_stall, .rsp_data,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // clock, period 12
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // sample both channels, run the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_valid && !req_stall) begin
            sb.note_input(req_data);
            req_taken = 1'b1;
            sent++;
            quiet_cycles = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_data);
            quiet_cycles = 0;
         end
         if (psel) quiet_cycles = 0;
         if (quiet_cycles >= WATCHDOG) begin
            $display("FAIL edge_map_pruning_filter_core");
            $finish;
         end
      end
   end

   // pick the idling phase from the transactions sent so far
   always @(negedge clock) begin
      case (sent / PHASE_LEN)
         0: begin idle_pct = 0; stall_pct = 0; end
         1: begin idle_pct = 55; stall_pct = 0; end
         2: begin idle_pct = 0; stall_pct = 55; end
         default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      // drive the request and stall
      if (!reset) begin
         if (!req_valid || req_taken) begin
            req_taken = 1'b0;
            if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pixel_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // register write: setup then access cycle
   task automatic csr_write(logic [1:0] idx, int unsigned value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:    sb.width_reg = value & 32'h7FF;
         REG_FRAME_HEIGHT:   sb.height_reg = value & 32'h7FF;
         REG_CONTRAST_THR:   sb.thr_reg = value & 32'hFF;
         REG_MIN_DIRECTIONS: sb.min_dir_reg = value & 32'hF;
         default: ;
      endcase
   endtask

   // hold until every result has come, then let the pipeline settle
   task automatic drain();
      while (pixel_q.size() != 0 || req_valid || sb.pending_px.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // queue one frame: blocky gray with noise, mixed edge bytes, stray flushes
   task automatic queue_frame(int w, int h, bit directed);
      req_type t;
      int n, sel;
      logic [7:0] lo, hi;
      lo = 8'($urandom_range(255));
      hi = 8'($urandom_range(255));
      n = 0;
      for (int r = 0; r < h; r++)
         for (int c = 0; c < w; c++) begin
            t.action = ACTION_PIXEL;
            if (directed && n < 20) begin
               t.gray = (n % 2) ? 8'd255 : 8'd0;
               t.edge_in = (n % 3 == 0) ? EDGE_MARK : (n % 3 == 1) ? 8'd0 : 8'h5A;
               if (n % 5 == 2) begin
                  // a flush before frame end is ignored
                  t.action = ACTION_FLUSH;
                  pixel_q = {pixel_q, t};
                  t.action = ACTION_PIXEL;
               end
            end else begin
               t.gray = (((r >> 2) + (c >> 2)) % 2) ? hi : lo;
               if ($urandom_range(3) == 0) t.gray = 8'($urandom_range(255));
               sel = $urandom_range(9);
               t.edge_in = (sel < 5) ? EDGE_MARK : (sel < 8) ? 8'd0 : 8'($urandom_range(255));
               if ($urandom_range(199) == 0) begin
                  t.action = ACTION_FLUSH;
                  pixel_q = {pixel_q, t};
                  t.action = ACTION_PIXEL;
               end
            end
            pixel_q = {pixel_q, t};
            n++;
         end
      // trailing items: flushes, or pixels that act as flushes
      for (int k = 0; k < LAG * w + LAG; k++) begin
         t.action = ($urandom_range(3) == 0) ? ACTION_PIXEL : ACTION_FLUSH;
         t.gray = 8'($urandom_range(255));
         t.edge_in = 8'($urandom_range(255));
         pixel_q = {pixel_q, t};
      end
   endtask

   task automatic run_frame(int w, int h, int thr, int mind, bit directed);
      csr_write(REG_FRAME_WIDTH, w);
      csr_write(REG_FRAME_HEIGHT, h);
      csr_write(REG_CONTRAST_THR, thr);
      csr_write(REG_MIN_DIRECTIONS, mind);
      queue_frame(w, h, directed);
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      run_frame(16, 16, 0, 0, 1);
      run_frame(17, 18, 30, 4, 0);
      run_frame(16, 20, 20, 3, 0);
      if (sb.mismatches == 0 && sb.pending_px.size() == 0)
         $display("PASS edge_map_pruning_filter_core");
      else
         $display("FAIL edge_map_pruning_filter_core");
      $finish;
   end
endmodule

/* filelist.f */
+incdir+hdl
hdl/empf_pkg.sv
hdl/edge_map_pruning_filter_core.sv
tb/sv/tb_edge_map_pruning_filter_core.sv
